// ----- hdl/bara_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bara_pkg
// Shared types and constants for the radix formatter.
// ----------------------------------------------------------------------------
package bara_pkg;

    localparam int unsigned CHAR_W = 8;
    localparam int unsigned CAP_W  = 8;
    localparam int unsigned FMT_W  = 3;

    typedef enum logic [FMT_W-1:0] {
        FMT_SDEC = 3'd0,
        FMT_UDEC = 3'd1,
        FMT_OCT  = 3'd2,
        FMT_HEX  = 3'd3
    } t_fmt;

    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2d;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_LOWA  = 8'h61;
    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;

    // one output beat as it leaves the emit stage
    typedef struct packed {
        logic [CHAR_W-1:0] out_char;
        logic              no_write;
        logic              is_last;
        logic [CAP_W-1:0]  end_offset;
    } t_beat;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d);
        logic [CHAR_W-1:0] r;
        if (d < 4'd10) r = CH_ZERO + {4'd0, d};
        else           r = CH_LOWA + {4'd0, d} - 8'd10;
        return r;
    endfunction

endpackage : bara_pkg
`default_nettype wire

// ----- hdl/bara_divstep.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bara_divstep
// One pipeline stage: extracts one digit per item in flight (radix 8/10/16).
// ----------------------------------------------------------------------------
module bara_divstep #(
    parameter int unsigned WIDTH = 32
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_en,
    input  wire logic             i_valid,
    input  wire logic [WIDTH-1:0] i_value,
    input  wire logic [1:0]       i_radix,   // 0 dec, 1 oct, 2 hex
    output      logic             o_valid,
    output      logic [WIDTH-1:0] o_quot,
    output      logic [3:0]       o_digit
);
    localparam int unsigned PW = WIDTH + 35;

    logic             r_valid;
    logic [WIDTH-1:0] r_quot;
    logic [3:0]       r_digit;
    logic [WIDTH-1:0] n_quot;
    logic [3:0]       n_digit;
    logic [PW-1:0]    w_prod;
    logic [WIDTH-1:0] w_q10;
    logic [WIDTH+3:0] w_back;

    // divide by ten through a reciprocal multiply; the digit is the remainder
    always_comb begin
        w_prod = {{(PW-WIDTH){1'b0}}, i_value} * PW'(35'h0CCCCCCCD);
        w_q10  = WIDTH'(w_prod >> 35);
        w_back = {4'd0, w_q10} * (WIDTH+4)'(10);
        case (i_radix)
            2'd0: begin
                n_quot  = w_q10;
                n_digit = 4'(i_value - w_back[WIDTH-1:0]);
            end
            2'd1: begin
                n_quot  = i_value >> 3;
                n_digit = {1'b0, i_value[2:0]};
            end
            default: begin
                n_quot  = i_value >> 4;
                n_digit = i_value[3:0];
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_quot  <= n_quot;
            r_digit <= n_digit;
        end
    end

    assign o_valid = r_valid;
    assign o_quot  = r_quot;
    assign o_digit = r_digit;
endmodule : bara_divstep
`default_nettype wire

// ----- hdl/binary_to_ascii_radix_formatter_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// binary_to_ascii_radix_formatter_core
// Integer to ASCII text in signed/unsigned decimal, octal or hex.
// ----------------------------------------------------------------------------
// Input beat: value, format, capacity. Output beats: one per written byte,
// most significant character first, then a NUL terminator flagged is_last
// with end_offset. Capacity zero gives one no_write beat.
// The conversion runs through a pipeline of MAX_CHARS-1 digit stages, one
// digit extracted per stage (reciprocal multiply for radix ten), plus an
// entry stage that takes the magnitude. An item passes the entry stage and
// the digit stages into the emit register, which presents its first output
// beat. From there the item is serialised one character per cycle unless
// the receiver stalls; it holds the emit register until its last beat
// (at most MAX_CHARS beats). While an item is being emitted the whole pipe,
// input included, holds; it moves on the cycle of the last beat.
// Reset (synchronous, active low) clears all valid bits. When the receiver
// stalls the whole pipe holds and the current beat stays on the outputs.
// ----------------------------------------------------------------------------
module binary_to_ascii_radix_formatter_core #(
    parameter int unsigned WIDTH     = 32,
    parameter int unsigned MAX_CHARS = 12
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output      logic                  o_stall,
    input  wire logic [31:0]           i_value,
    input  wire logic [bara_pkg::FMT_W-1:0]  i_format,
    input  wire logic [bara_pkg::CAP_W-1:0]  i_capacity,
    output      logic                  o_valid,
    input  wire logic                  i_stall,
    output      logic [bara_pkg::CHAR_W-1:0] o_out_char,
    output      logic                  o_no_write,
    output      logic                  o_is_last,
    output      logic [bara_pkg::CAP_W-1:0]  o_end_offset
);
    import bara_pkg::*;

    localparam int unsigned ND  = MAX_CHARS - 1;   // digit stages
    localparam int unsigned NDW = $clog2(MAX_CHARS + 1);

    // ---------------- entry stage ----------------
    logic             r0_valid;
    logic [WIDTH-1:0] r0_mag;
    logic [1:0]       r0_radix;
    logic             r0_neg;
    logic [CAP_W-1:0] r0_cap;
    logic             w_adv;
    logic [WIDTH-1:0] w_in;
    logic             w_neg;

    assign w_in  = i_value[WIDTH-1:0];
    assign w_neg = (i_format == FMT_SDEC) && w_in[WIDTH-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_valid <= 1'b0;
        end else if (w_adv) begin
            r0_valid <= i_valid;
        end
        if (w_adv) begin
            r0_mag   <= w_neg ? (~w_in + WIDTH'(1)) : w_in;
            r0_neg   <= w_neg;
            r0_cap   <= i_capacity;
            case (i_format)
                FMT_SDEC, FMT_UDEC: r0_radix <= 2'd0;
                FMT_OCT:            r0_radix <= 2'd1;
                default:            r0_radix <= 2'd2;
            endcase
        end
    end
    assign o_stall = !w_adv;

    // ---------------- digit stages ----------------
    logic [WIDTH-1:0] w_q   [ND+1];
    logic             w_v   [ND+1];
    logic [3:0]       w_d   [ND];
    logic [1:0]       r_rad [ND];
    logic             r_ng  [ND];
    logic [CAP_W-1:0] r_cp  [ND];
    logic [NDW-1:0]   r_cnt [ND];
    // digits collected per stage, least significant first
    logic [3:0]       r_dg  [ND][ND];
    logic [3:0]       r_dg_view [ND][ND];

    assign w_q[0] = r0_mag;
    assign w_v[0] = r0_valid;

    for (genvar s = 0; s < ND; s++) begin : g_st
        logic [1:0]       w_rad_in;
        logic             w_ng_in;
        logic [CAP_W-1:0] w_cp_in;
        logic [NDW-1:0]   w_cnt_in;
        logic             w_done_in;
        if (s == 0) begin : g_first
            assign w_rad_in = r0_radix;
            assign w_ng_in  = r0_neg;
            assign w_cp_in  = r0_cap;
            assign w_cnt_in = '0;
            assign w_done_in = 1'b0;
        end else begin : g_rest
            assign w_rad_in = r_rad[s-1];
            assign w_ng_in  = r_ng[s-1];
            assign w_cp_in  = r_cp[s-1];
            assign w_cnt_in = r_cnt[s-1];
            // stop on zero quotient or at the character limit
            assign w_done_in = (w_q[s] == '0) ||
                (NDW'(w_cnt_in) >= NDW'(ND) - NDW'(w_ng_in));
        end

        bara_divstep #(.WIDTH(WIDTH)) u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_adv),
            .i_valid (w_v[s]),
            .i_value (w_q[s]),
            .i_radix (w_rad_in),
            .o_valid (w_v[s+1]),
            .o_quot  (w_q[s+1]),
            .o_digit (w_d[s])
        );

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_rad[s] <= w_rad_in;
                r_ng[s]  <= w_ng_in;
                r_cp[s]  <= w_cp_in;
                r_cnt[s] <= w_done_in ? w_cnt_in : w_cnt_in + NDW'(1);
            end
        end
        if (s > 0) begin : g_copy
            // earlier digits, the previous stage's own digit included
            always_ff @(posedge i_clk) begin
                if (w_adv) begin
                    for (int k = 0; k < s; k++) r_dg[s][k] <= r_dg_view[s-1][k];
                end
            end
        end
        // the digit of this stage is held in the divider output register
        for (genvar k = 0; k < ND; k++) begin : g_view
            if (k == s) begin : g_own
                assign r_dg_view[s][k] = w_d[s];
            end else if (k < s) begin : g_old
                assign r_dg_view[s][k] = r_dg[s][k];
            end else begin : g_none
                assign r_dg_view[s][k] = 4'd0;
            end
        end
    end

    // ---------------- emit stage ----------------
    logic             r_ev;          // emit register holds an item
    logic [3:0]       r_ed [ND];
    logic             r_eneg;
    logic [CAP_W-1:0] r_ecap;
    logic [NDW-1:0]   r_en;          // digit count
    logic [CAP_W-1:0] r_ek;          // characters emitted so far
    logic             w_tail_v;
    logic [NDW-1:0]   w_tail_n;
    logic [CAP_W:0]   w_total;
    logic             w_last;
    logic             w_beat;
    t_beat            w_b;
    logic [CAP_W:0]   w_pos;
    logic [NDW-1:0]   w_di;

    assign w_tail_v = w_v[ND];
    // final count: the count of stage ND-1 includes its own digit
    assign w_tail_n = r_cnt[ND-1];

    assign w_total = CAP_W'(r_en) + (CAP_W+1)'(r_eneg);
    assign w_pos   = {1'b0, r_ek};

    always_comb begin
        w_b.no_write   = 1'b0;
        w_b.is_last    = 1'b0;
        w_b.end_offset = '0;
        w_b.out_char   = CH_NUL;
        w_di           = '0;
        if (r_ecap == '0) begin
            w_b.no_write = 1'b1;
            w_b.is_last  = 1'b1;
        end else if (w_pos == w_total) begin
            w_b.is_last    = 1'b1;
            w_b.end_offset = CAP_W'(w_total);
        end else if (w_pos == (CAP_W+1)'(r_ecap) - 1'b1) begin
            w_b.is_last    = 1'b1;
            w_b.end_offset = r_ecap;
        end else if (r_eneg && r_ek == '0) begin
            w_b.out_char = CH_MINUS;
        end else begin
            w_di = NDW'(w_total - w_pos - 1'b1);
            w_b.out_char = digit_char(r_ed[w_di[$clog2(ND)-1:0]]);
        end
    end

    assign w_last = w_b.is_last;
    assign w_beat = r_ev && !i_stall;
    // pipe moves when the emit register is free or finishing this cycle
    assign w_adv  = !r_ev || (w_beat && w_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ev <= 1'b0;
            r_ek <= '0;
        end else if (w_adv) begin
            r_ev <= w_tail_v;
            r_ek <= '0;
        end else if (w_beat) begin
            r_ek <= r_ek + CAP_W'(1);
        end
        if (w_adv) begin
            for (int k = 0; k < ND; k++) r_ed[k] <= r_dg_view[ND-1][k];
            r_eneg <= r_ng[ND-1];
            r_ecap <= r_cp[ND-1];
            r_en   <= (w_tail_n == '0) ? NDW'(1) : w_tail_n;
        end
    end

    assign o_valid      = r_ev;
    assign o_out_char   = w_b.out_char;
    assign o_no_write   = w_b.no_write;
    assign o_is_last    = w_b.is_last;
    assign o_end_offset = w_b.end_offset;

endmodule : binary_to_ascii_radix_formatter_core
`default_nettype wire

// ----- hdl/bara_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bara_port_checker
// Port-level checks for the radix formatter.
// ----------------------------------------------------------------------------
module bara_port_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_valid,
    input wire logic       i_stall,
    input wire logic [7:0] o_out_char,
    input wire logic       o_no_write,
    input wire logic       o_is_last,
    input wire logic [7:0] o_end_offset
);
    // a stalled beat holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_out_char)
            && $stable(o_is_last)))
        else $error("stalled beat changed");

    a_nw_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_no_write) |-> o_is_last)
        else $error("no_write beat not last");

    a_nul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_is_last) |-> (o_out_char == 8'd0))
        else $error("last beat not NUL");

    a_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_is_last) |-> (o_end_offset == 8'd0 && o_out_char != 8'd0))
        else $error("bad mid beat");
endmodule : bara_port_checker

bind binary_to_ascii_radix_formatter_core bara_port_checker u_bara_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_out_char   (o_out_char),
    .o_no_write   (o_no_write),
    .o_is_last    (o_is_last),
    .o_end_offset (o_end_offset)
);
`default_nettype wire
